[hdl/assert_macros.svh]
// Assertion helpers; both expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hdl/ght_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package ght_pkg;

    localparam int SLOTS    = 64;
    localparam int IDX_W    = $clog2(SLOTS);
    localparam int GEN_W    = 32;
    localparam int OBJ_W    = 32;
    localparam int IDXF_W   = 32;
    localparam int HANDLE_W = 64;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 3;
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    localparam logic [REQ_W-1:0] REQ_MINT   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DROP   = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NULL      = 3'd1,
        ST_FULL      = 3'd2,
        ST_MALFORMED = 3'd3,
        ST_STALE     = 3'd4
    } status_t;

    // Outcome decided up front; mint/lookup/drop still need the table.
    typedef enum logic [2:0] {
        CLS_MINT,
        CLS_LOOKUP,
        CLS_DROP,
        CLS_NULL,
        CLS_MALFORMED
    } cls_t;

    typedef struct packed {
        cls_t             cls;
        logic [OBJ_W-1:0] obj;
        logic [IDX_W-1:0] idx;
        logic [GEN_W-1:0] gen;
    } entry_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [OBJ_W-1:0]    object;
        status_t             status;
    } result_t;

    typedef enum logic {
        B_IDLE,
        B_CHECK
    } back_state_t;

endpackage
`default_nettype wire

[hdl/ght_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface ght_req_if;
    import ght_pkg::*;

    logic                valid;
    logic                ready;
    logic [REQ_W-1:0]    req_type;
    logic [OBJ_W-1:0]    object_ref;
    logic [HANDLE_W-1:0] handle_in;

    modport source (output valid, output req_type, output object_ref, output handle_in,
                    input ready);
    modport sink   (input valid, input req_type, input object_ref, input handle_in,
                    output ready);
endinterface
`default_nettype wire

[hdl/ght_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface ght_rsp_if;
    import ght_pkg::*;

    logic                valid;
    logic                ready;
    logic [HANDLE_W-1:0] handle_out;
    logic [OBJ_W-1:0]    object_out;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output handle_out, output object_out, output status,
                    input ready);
    modport sink   (input valid, input handle_out, input object_out, input status,
                    output ready);
endinterface
`default_nettype wire

[hdl/ght_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module ght_front (
    ght_req_if.sink         req,
    input  logic            q_full,
    output logic            push,
    output ght_pkg::entry_t push_data
);
    import ght_pkg::*;

    logic [IDXF_W-1:0] idx_field;
    logic [GEN_W-1:0]  gen_field;
    logic              well_formed;

    assign idx_field   = req.handle_in[IDXF_W-1:0];
    assign gen_field   = req.handle_in[HANDLE_W-1 -: GEN_W];
    assign well_formed = (idx_field < IDXF_W'(SLOTS)) && (gen_field != '0);

    assign req.ready = !q_full;
    assign push      = req.valid && !q_full;

    always_comb
    begin
        push_data.obj = req.object_ref;
        push_data.idx = idx_field[IDX_W-1:0];
        push_data.gen = gen_field;
        unique case (req.req_type)
            REQ_MINT:   push_data.cls = (req.object_ref == '0) ? CLS_NULL : CLS_MINT;
            REQ_LOOKUP: push_data.cls = well_formed ? CLS_LOOKUP : CLS_MALFORMED;
            REQ_DROP:   push_data.cls = well_formed ? CLS_DROP : CLS_MALFORMED;
            default:    push_data.cls = CLS_MALFORMED;
        endcase
    end

endmodule
`default_nettype wire

[hdl/ght_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
module ght_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ght_pkg::entry_t push_data,
    output logic            full,
    output logic            q_valid,
    input  logic            pop,
    output ght_pkg::entry_t q_data
);
    import ght_pkg::*;

    entry_t              store_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign full    = (count_reg == QCNT_W'(QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

`include "assert_macros.svh"

    `ASSERT_IMPL(a_no_overflow, push && !pop, !full)
    `ASSERT_IMPL(a_no_underflow, pop, q_valid)

endmodule
`default_nettype wire

[hdl/ght_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module ght_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  ght_pkg::entry_t q_data,
    output logic            pop,
    ght_rsp_if.source       rsp
);
    import ght_pkg::*;

    back_state_t            state_reg, state_next;
    logic [SLOTS-1:0]       used_reg, used_next;
    logic [GEN_W-1:0]       next_gen_reg, next_gen_next;
    logic                   out_valid_reg, out_valid_next;
    result_t                res_reg, res_next;
    entry_t                 ent_reg;
    logic [GEN_W+OBJ_W-1:0] mem [SLOTS];
    logic [GEN_W+OBJ_W-1:0] rd_data_reg;

    logic                   out_free;
    logic                   res_load;
    logic                   rd_en;
    logic                   mint_ok;
    logic                   drop_ok;
    logic                   any_free;
    logic [IDX_W-1:0]       free_idx;
    logic [GEN_W-1:0]       gen_inc;
    logic [GEN_W-1:0]       rd_gen;
    logic [OBJ_W-1:0]       rd_obj;
    logic                   hit;

    assign out_free = !out_valid_reg || rsp.ready;
    assign rd_gen   = rd_data_reg[GEN_W+OBJ_W-1 -: GEN_W];
    assign rd_obj   = rd_data_reg[OBJ_W-1:0];
    assign hit      = used_reg[ent_reg.idx] && (rd_gen == ent_reg.gen);
    assign gen_inc  = next_gen_reg + 1'b1;

    // lowest free slot
    always_comb
    begin
        any_free = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                any_free = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        pop           = 1'b0;
        res_load      = 1'b0;
        res_next      = '{handle: '0, object: '0, status: ST_MALFORMED};
        rd_en         = 1'b0;
        mint_ok       = 1'b0;
        drop_ok       = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    pop = 1'b1;
                    unique case (q_data.cls) inside
                        CLS_NULL:
                        begin
                            res_load        = 1'b1;
                            res_next.status = ST_NULL;
                        end
                        CLS_MINT:
                        begin
                            res_load = 1'b1;
                            if (any_free)
                            begin
                                mint_ok         = 1'b1;
                                res_next.handle = {next_gen_reg, IDXF_W'(free_idx)};
                                res_next.status = ST_OK;
                            end
                            else
                            begin
                                res_next.status = ST_FULL;
                            end
                        end
                        CLS_LOOKUP, CLS_DROP:
                        begin
                            rd_en      = 1'b1;
                            state_next = B_CHECK;
                        end
                        default:
                        begin
                            res_load        = 1'b1;
                            res_next.status = ST_MALFORMED;
                        end
                    endcase
                end
            end
            B_CHECK:
            begin
                if (out_free)
                begin
                    res_load   = 1'b1;
                    state_next = B_IDLE;
                    if (ent_reg.cls == CLS_LOOKUP)
                    begin
                        if (hit && rd_obj != '0)
                        begin
                            res_next.object = rd_obj;
                            res_next.status = ST_OK;
                        end
                        else
                        begin
                            res_next.status = ST_STALE;
                        end
                    end
                    else
                    begin
                        drop_ok         = hit;
                        res_next.status = hit ? ST_OK : ST_STALE;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        used_next     = used_reg;
        next_gen_next = next_gen_reg;
        if (mint_ok)
        begin
            used_next[free_idx] = 1'b1;
            next_gen_next       = (gen_inc == '0) ? GEN_W'(1) : gen_inc;
        end
        if (drop_ok)
        begin
            used_next[ent_reg.idx] = 1'b0;
        end
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            used_reg      <= '0;
            next_gen_reg  <= GEN_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            next_gen_reg  <= next_gen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res_next;
        end
        if (pop)
        begin
            ent_reg <= q_data;
        end
    end

    // slot store: {generation, object}; read data counts only where the used bit is set
    always_ff @(posedge clk)
    begin
        if (mint_ok)
        begin
            mem[free_idx] <= {next_gen_reg, q_data.obj};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[q_data.idx];
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.handle_out = res_reg.handle;
    assign rsp.object_out = res_reg.object;
    assign rsp.status     = res_reg.status;

`include "assert_macros.svh"

    `ASSERT_IMPL(a_gen_nonzero, 1'b1, next_gen_reg != '0)
    `ASSERT_NEXT(a_mint_marks, mint_ok, used_reg[$past(free_idx)])
    `ASSERT_NEXT(a_drop_frees, drop_ok, !used_reg[$past(ent_reg.idx)])
    `ASSERT_IMPL(a_check_not_blocked_by_mint, state_reg == B_CHECK, !mint_ok)

endmodule
`default_nettype wire

[hdl/generation_handle_table.sv]
// Path: mint and rejected requests pass the request queue and the result
//   register; lookup and drop also pass the registered slot read.
// Throughput: one mint or rejected request per cycle while results are taken;
//   lookup and drop pop no further request until their slot read is checked.
// Reset: rst_n clears all used bits, the request queue and the result valid
//   flag, and sets the next generation to 1; the slot store is not reset.
`timescale 1ns / 1ps
`default_nettype none
module generation_handle_table (
    input  logic      clk,
    input  logic      rst_n,
    ght_req_if.sink   req,
    ght_rsp_if.source rsp
);
    import ght_pkg::*;

    // Front end: decode the request and the handle fields, reject null
    // objects, malformed handles and unknown opcodes before the table.
    logic   push;
    entry_t push_data;
    logic   q_full;

    // Two-entry queue decouples request transfers from table work.
    logic   q_valid;
    logic   pop;
    entry_t q_data;

    ght_front u_front (
        .req       (req),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    ght_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .q_valid   (q_valid),
        .pop       (pop),
        .q_data    (q_data)
    );

    // Back end: owns the used bits, slot store and generation counter, and
    // holds finished results in an output register until transfer.
    ght_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_data),
        .pop     (pop),
        .rsp     (rsp)
    );

endmodule
`default_nettype wire
